>>> rtl/lcsl_pkg.sv
// Package: types, constants and helpers for the longest common substring length block.
`timescale 1ns / 1ps

package lcsl_pkg;

   // Default pattern capacity
   localparam int PATTERN_MAX_DEF = 32;

   // Character and count widths
   localparam int CHAR_W = 16;
   localparam int CNT_W  = 6;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Request commands
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Request payload
   typedef struct packed {
      cmd_type            cmd;
      logic [CHAR_W-1:0]  ch;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [CNT_W-1:0]   match_length;
      logic               pattern_truncated;
   } rsp_type;

   // Controls broadcast to every cell
   typedef struct packed {
      logic clear_pat;   // drop pattern, counts and local maxima
      logic clear_cnt;   // end of text: zero running counts
      logic text_en;     // text character present on ch
      logic shift;       // move local maxima one cell up the row
   } cell_ctl_type;

   // Larger of two counts
   function automatic logic [CNT_W-1:0] max_cnt(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      max_cnt = (a > b) ? a : b;
   endfunction

endpackage

>>> rtl/lcsl_cell.sv
// One pattern position: stored character, running match count and local maximum.
`timescale 1ns / 1ps

module lcsl_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  lcsl_pkg::cell_ctl_type              ctl,
   input  logic                                wr_en,
   input  logic [lcsl_pkg::CHAR_W-1:0]         ch,
   input  logic [lcsl_pkg::CNT_W-1:0]          prev_count,
   input  logic [lcsl_pkg::CNT_W-1:0]          prev_best,
   output logic [lcsl_pkg::CNT_W-1:0]          count,
   output logic [lcsl_pkg::CNT_W-1:0]          best
);

   logic [lcsl_pkg::CHAR_W-1:0] char_ff;
   logic                        valid_ff;
   logic [lcsl_pkg::CNT_W-1:0]  count_ff;
   logic [lcsl_pkg::CNT_W-1:0]  best_ff;
   logic [lcsl_pkg::CNT_W-1:0]  inc_cnt;
   logic [lcsl_pkg::CNT_W-1:0]  count_in;

   // Neighbor's old count plus one, saturating
   assign inc_cnt  = (prev_count == lcsl_pkg::CNT_MAX) ? lcsl_pkg::CNT_MAX
                                                      : prev_count + 1'b1;
   assign count_in = (valid_ff && (char_ff == ch)) ? inc_cnt : '0;

   // Pattern character, written once on append
   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_ff <= ch;
      end
   end

   // Control and count state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         best_ff  <= '0;
      end else begin
         priority if (ctl.clear_pat) begin
            valid_ff <= 1'b0;
            count_ff <= '0;
            best_ff  <= '0;
         end else if (wr_en) begin
            valid_ff <= 1'b1;
            count_ff <= '0;
         end else if (ctl.clear_cnt) begin
            count_ff <= '0;
         end else if (ctl.text_en) begin
            count_ff <= count_in;
            best_ff  <= lcsl_pkg::max_cnt(best_ff, count_in);
         end else if (ctl.shift) begin
            best_ff  <= prev_best;
         end
      end
   end

   assign count = count_ff;
   assign best  = best_ff;

endmodule

>>> rtl/longest_common_substring_length.sv
// Top level: row of match cells, pattern length, drain sequencer and result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | lcsl_pkg::req_type (cmd, ch)
//   rsp     | out       | rsp_valid/rsp_stall  | lcsl_pkg::rsp_type (match_length, pattern_truncated)
//
// Clear, append and text requests are handled at once, with no drain; every cell updates its count at once.
// End of text drains the row: the local maxima are shifted up the row, one
// cell a cycle, into a running maximum at the top, then the result register is loaded.
// Reset (synchronous) empties the pattern and zeros all counts.
// A stalled result holds; requests still go through meanwhile, until a later end of text must wait to load its result.
`timescale 1ns / 1ps

module longest_common_substring_length #(
   parameter int PATTERN_MAX = lcsl_pkg::PATTERN_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcsl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcsl_pkg::rsp_type rsp_data
);

   localparam int LW = $clog2(PATTERN_MAX + 1);
   localparam int DW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   lcsl_pkg::state_type          state_ff, state_in;
   logic [LW-1:0]                len_ff, len_in;
   logic                         trunc_ff, trunc_in;
   logic [lcsl_pkg::CNT_W-1:0]   acc_ff, acc_in;
   logic [DW-1:0]                drain_ff, drain_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lcsl_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                         req_acc;
   lcsl_pkg::cell_ctl_type       ctl;
   logic                         append;
   logic [lcsl_pkg::CNT_W-1:0]   count_w [PATTERN_MAX];
   logic [lcsl_pkg::CNT_W-1:0]   best_w  [PATTERN_MAX];

   assign req_stall = (state_ff != lcsl_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign append    = req_acc && (req_data.cmd == lcsl_pkg::CMD_APPEND);

   // Broadcast controls
   always_comb begin
      ctl.clear_pat = req_acc && (req_data.cmd == lcsl_pkg::CMD_CLEAR);
      ctl.clear_cnt = req_acc && (req_data.cmd == lcsl_pkg::CMD_END);
      ctl.text_en   = req_acc && (req_data.cmd == lcsl_pkg::CMD_TEXT);
      ctl.shift     = (state_ff == lcsl_pkg::ST_DRAIN);
   end

   // Row of cells; cell 0 sees zero from below
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      logic [lcsl_pkg::CNT_W-1:0] pc;
      logic [lcsl_pkg::CNT_W-1:0] pb;
      if (i == 0) begin : g_first
         assign pc = '0;
         assign pb = '0;
      end else begin : g_rest
         assign pc = count_w[i-1];
         assign pb = best_w[i-1];
      end
      lcsl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_en      (append && (len_ff == LW'(i))),
         .ch         (req_data.ch),
         .prev_count (pc),
         .prev_best  (pb),
         .count      (count_w[i]),
         .best       (best_w[i])
      );
   end

   // Sequencer, pattern length and result register
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      trunc_in     = trunc_ff;
      acc_in       = acc_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         lcsl_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (req_data.cmd)
                  lcsl_pkg::CMD_CLEAR: begin
                     len_in   = '0;
                     trunc_in = 1'b0;
                  end
                  lcsl_pkg::CMD_APPEND: begin
                     if (len_ff < LW'(PATTERN_MAX)) begin
                        len_in = len_ff + 1'b1;
                     end else begin
                        trunc_in = 1'b1;
                     end
                  end
                  lcsl_pkg::CMD_TEXT: begin
                  end
                  lcsl_pkg::CMD_END: begin
                     acc_in   = '0;
                     drain_in = '0;
                     state_in = lcsl_pkg::ST_DRAIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lcsl_pkg::ST_DRAIN: begin
            acc_in   = lcsl_pkg::max_cnt(acc_ff, best_w[PATTERN_MAX-1]);
            drain_in = drain_ff + 1'b1;
            if (drain_ff == DW'(PATTERN_MAX - 1)) begin
               state_in = lcsl_pkg::ST_DONE;
            end
         end
         lcsl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.match_length      = acc_ff;
               rsp_data_in.pattern_truncated = trunc_ff;
               state_in                      = lcsl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcsl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcsl_pkg::ST_IDLE;
         len_ff       <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      drain_ff    <= drain_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/lcsl_chk.sv
// Port-level checker for the longest common substring length block, with its bind.
`timescale 1ns / 1ps

module lcsl_chk #(
   parameter int PATTERN_MAX = lcsl_pkg::PATTERN_MAX_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lcsl_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lcsl_pkg::rsp_type rsp_data
);

   localparam int CAP_I = (PATTERN_MAX < 63) ? PATTERN_MAX : 63;
   localparam logic [lcsl_pkg::CNT_W-1:0] CAP = lcsl_pkg::CNT_W'(CAP_I);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // End of text keeps the request side busy while the row drains
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.cmd == lcsl_pkg::CMD_END) |=> req_stall)
      else $error("end of text did not start drain");

   // A new result only follows a busy cycle
   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without drain");

   // Length never exceeds the pattern capacity
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.match_length <= CAP)
      else $error("match length above capacity");

endmodule

bind longest_common_substring_length lcsl_chk #(.PATTERN_MAX(PATTERN_MAX)) u_lcsl_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> verif/lcsl_checker.sv
// Checker: watches both channels, predicts each match length and compares the results.
`timescale 1ns / 1ps

module lcsl_checker #(
   parameter int PATTERN_MAX = lcsl_pkg::PATTERN_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lcsl_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lcsl_pkg::rsp_type rsp_data,
   output int                errors,
   output int                pending,
   output int                results_seen,
   output int                truncated_seen
);

   // Shadow copy of the pattern, the per-position runs and the running best
   logic [lcsl_pkg::CHAR_W-1:0] pat_chars [PATTERN_MAX];
   int                          pat_len;
   logic [lcsl_pkg::CNT_W-1:0]  run_len [PATTERN_MAX];
   logic [lcsl_pkg::CNT_W-1:0]  best_run;
   logic                        pat_trunc;
   lcsl_pkg::rsp_type           lcs_expected [$];

   initial begin
      errors         = 0;
      pending        = 0;
      results_seen   = 0;
      truncated_seen = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
   endtask

   task automatic clear_runs();
      foreach (run_len[i]) run_len[i] = '0;
      best_run = '0;
   endtask

   // Advance the shadow state by one accepted request
   task automatic predict_lcs(input lcsl_pkg::req_type r);
      int                         pos;
      logic [lcsl_pkg::CNT_W-1:0] prev;
      logic [lcsl_pkg::CNT_W-1:0] nxt;
      lcsl_pkg::rsp_type          res;
      case (r.cmd)
         lcsl_pkg::CMD_CLEAR: begin
            pat_len   = 0;
            pat_trunc = 1'b0;
            clear_runs();
         end
         lcsl_pkg::CMD_APPEND: begin
            // a full pattern drops the character and remembers the truncation
            if (pat_len < PATTERN_MAX) begin
               pat_chars[pat_len] = r.ch;
               run_len[pat_len]   = '0;
               pat_len++;
            end else begin
               pat_trunc = 1'b1;
            end
         end
         lcsl_pkg::CMD_TEXT: begin
            // top-down so each position still sees its neighbor's old run
            for (int i = pat_len; i > 0; i--) begin
               pos = i - 1;
               nxt = '0;
               if (pat_chars[pos] == r.ch) begin
                  prev = (pos == 0) ? '0 : run_len[pos-1];
                  nxt  = (prev >= lcsl_pkg::CNT_MAX) ? lcsl_pkg::CNT_MAX : prev + 1'b1;
               end
               run_len[pos] = nxt;
               if (nxt > best_run) best_run = nxt;
            end
         end
         lcsl_pkg::CMD_END: begin
            res.match_length      = best_run;
            res.pattern_truncated = pat_trunc;
            lcs_expected = {lcs_expected, res};
            clear_runs();
         end
      endcase
   endtask

   // Results are checked before the same edge's request is applied
   always @(posedge clock) begin : watch
      lcsl_pkg::rsp_type want;
      if (reset) begin
         pat_len   = 0;
         pat_trunc = 1'b0;
         clear_runs();
         lcs_expected.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (lcs_expected.size() == 0) begin
               report_mismatch($sformatf(
                  "result length %0d truncated %0b with no end of text pending",
                  rsp_data.match_length, rsp_data.pattern_truncated));
            end else begin
               want = lcs_expected.pop_front();
               if (want.pattern_truncated) truncated_seen++;
               if (rsp_data.match_length !== want.match_length)
                  report_mismatch($sformatf("match_length got %0d expected %0d",
                                            rsp_data.match_length, want.match_length));
               if (rsp_data.pattern_truncated !== want.pattern_truncated)
                  report_mismatch($sformatf("pattern_truncated got %b expected %b",
                                            rsp_data.pattern_truncated, want.pattern_truncated));
            end
         end
         if (req_valid && !req_stall) predict_lcs(req_data);
      end
      pending = lcs_expected.size();
   end

endmodule

>>> verif/tb_top.sv
// Testbench top: clock, reset, request and stall stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int PAT_MAX     = lcsl_pkg::PATTERN_MAX_DEF;
   localparam int CW          = lcsl_pkg::CHAR_W;
   localparam int ITEM_TARGET = 1050;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   lcsl_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   lcsl_pkg::rsp_type rsp_data;

   int errors;
   int pending;
   int results_seen;
   int truncated_seen;
   int n_sent;
   int n_by_cmd [4];
   bit steady;

   longest_common_substring_length #(.PATTERN_MAX(PAT_MAX)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   lcsl_checker #(.PATTERN_MAX(PAT_MAX)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .errors         (errors),
      .pending        (pending),
      .results_seen   (results_seen),
      .truncated_seen (truncated_seen)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 10);
      else return $urandom_range(20, 60);
   endfunction

   // One request: optional gap, then hold until accepted; returns on a falling edge
   task automatic send_req(input lcsl_pkg::cmd_type c, input logic [CW-1:0] d);
      int gap;
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {c, d};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
      n_by_cmd[c]++;
      @(negedge clock);
   endtask

   // Hold off the sender until every pending result is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // One search: optional clear, a pattern from a small alphabet, then texts
   task automatic run_search(input bit force_long);
      logic [CW-1:0] sym [4];
      logic [CW-1:0] pat [40];
      int plen, tlen, k, start, run, r;
      foreach (sym[i]) sym[i] = CW'($urandom);
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) send_req(lcsl_pkg::CMD_CLEAR, CW'($urandom));
      r = $urandom_range(0, 99);
      if (force_long) plen = $urandom_range(PAT_MAX + 1, PAT_MAX + 4);
      else if (r < 3) plen = 0;
      else if (r < 85) plen = $urandom_range(1, 12);
      else if (r < 95) plen = $urandom_range(13, PAT_MAX);
      else plen = $urandom_range(PAT_MAX - 2, PAT_MAX + 4);
      for (int i = 0; i < plen; i++) begin
         pat[i] = ($urandom_range(0, 9) == 0) ? CW'($urandom) : sym[$urandom_range(0, 3)];
         send_req(lcsl_pkg::CMD_APPEND, pat[i]);
      end
      repeat ($urandom_range(1, 3)) begin
         tlen = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
         k = 0;
         while (k < tlen) begin
            r = $urandom_range(0, 99);
            if (r < 45 && plen > 0) begin
               // copy a slice of the pattern so long matches occur
               start = $urandom_range(0, plen - 1);
               run   = $urandom_range(1, plen - start);
               for (int j = 0; j < run; j++) send_req(lcsl_pkg::CMD_TEXT, pat[start+j]);
               k += run;
            end else if (r < 90) begin
               send_req(lcsl_pkg::CMD_TEXT, sym[$urandom_range(0, 3)]);
               k++;
            end else if (r < 94) begin
               send_req(lcsl_pkg::CMD_TEXT, CW'($urandom));
               k++;
            end else if (r < 97) begin
               // pattern grows in the middle of a text
               if (plen < 40) begin
                  pat[plen] = sym[$urandom_range(0, 3)];
                  send_req(lcsl_pkg::CMD_APPEND, pat[plen]);
                  plen++;
               end
            end else begin
               send_req(lcsl_pkg::cmd_type'($urandom_range(0, 3)), CW'($urandom));
               k++;
            end
         end
         send_req(lcsl_pkg::CMD_END, CW'($urandom));
      end
   endtask

   // Result-side stall: bursts of random stalls between stall-free stretches
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 150)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (idle_len() + 1) @(negedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   // Main stimulus and verdict
   initial begin
      int seq;
      int waited;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      steady    = 1'b0;
      n_sent    = 0;
      foreach (n_by_cmd[i]) n_by_cmd[i] = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty pattern, all-ones/all-zeros chars, append during text
      send_req(lcsl_pkg::CMD_END,    16'h0000);
      send_req(lcsl_pkg::CMD_TEXT,   16'hFFFF);
      send_req(lcsl_pkg::CMD_END,    16'hFFFF);
      send_req(lcsl_pkg::CMD_APPEND, 16'hFFFF);
      send_req(lcsl_pkg::CMD_APPEND, 16'h0000);
      send_req(lcsl_pkg::CMD_APPEND, 16'hFFFF);
      send_req(lcsl_pkg::CMD_TEXT,   16'h0000);
      send_req(lcsl_pkg::CMD_TEXT,   16'hFFFF);
      send_req(lcsl_pkg::CMD_TEXT,   16'h0000);
      send_req(lcsl_pkg::CMD_END,    16'h0000);
      send_req(lcsl_pkg::CMD_TEXT,   16'hAAAA);
      send_req(lcsl_pkg::CMD_APPEND, 16'hAAAA);
      send_req(lcsl_pkg::CMD_TEXT,   16'hAAAA);
      send_req(lcsl_pkg::CMD_TEXT,   16'h5555);
      send_req(lcsl_pkg::CMD_END,    16'h5555);
      send_req(lcsl_pkg::CMD_CLEAR,  16'hAAAA);
      send_req(lcsl_pkg::CMD_APPEND, 16'h5555);
      send_req(lcsl_pkg::CMD_TEXT,   16'h5555);
      // clear in the middle of a text drops the running counts
      send_req(lcsl_pkg::CMD_CLEAR,  16'h5555);
      send_req(lcsl_pkg::CMD_END,    16'hAAAA);
      send_req(lcsl_pkg::CMD_TEXT,   16'h5555);
      send_req(lcsl_pkg::CMD_END,    16'hFFFF);
      wait_drained();

      // random searches; the second one overfills the pattern
      seq = 0;
      while (n_sent < ITEM_TARGET) begin
         run_search(seq == 1);
         seq++;
         if (seq % 8 == 0) wait_drained();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // let the last results drain, then idle before the verdict
      waited = 0;
      while (pending != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (PAT_MAX + 10) @(negedge clock);
      if (pending != 0) $display("%0d expected results never arrived", pending);

      $display("Sent %0d requests: %0d clear, %0d append, %0d text, %0d end of text",
               n_sent, n_by_cmd[lcsl_pkg::CMD_CLEAR], n_by_cmd[lcsl_pkg::CMD_APPEND],
               n_by_cmd[lcsl_pkg::CMD_TEXT], n_by_cmd[lcsl_pkg::CMD_END]);
      $display("Checked %0d match lengths, %0d with a truncated pattern; %0d mismatches",
               results_seen, truncated_seen, errors);
      if (errors == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("Timeout: run did not complete");
      $display("FAIL");
      $finish;
   end

endmodule
